// ===== design/lrpf_pkg.sv =====
package lrpf_pkg;

  localparam int unsigned ROWS_PER_PAGE = 8;

  localparam logic [1:0] CMD_LINE  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic       pixel_on;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] column_byte;
    logic [8:0] pixels_written;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic rd_pix;
    logic wr_pix;
    logic rd_byte;
    logic clr;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] in_cmd;
    logic       last_pixel;
    logic       clr_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== design/lrpf_datapath.sv =====
module lrpf_datapath #(
  parameter int unsigned PANEL_WIDTH  = 128,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrpf_pkg::in_item_t   in_data,
  input  lrpf_pkg::ctrl_cmd_t  cmd,
  output lrpf_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lrpf_pkg::out_item_t  out_data
);
  import lrpf_pkg::*;

  localparam int unsigned PAGES = (PANEL_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int unsigned DEPTH = PAGES * PANEL_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  logic [1:0]           cmd_r;
  logic [7:0]           x_r, y_r, ex_r, ey_r;
  logic [7:0]           dx_r, dy_r;
  logic                 sx_neg_r, sy_neg_r;
  logic signed [10:0]   err_r;
  logic                 on_r;
  logic [8:0]           count_r;
  logic [AW-1:0]        addr_r;
  logic [7:0]           mask_r;
  logic                 inside_r;
  logic [AW-1:0]        byte_addr_r;
  logic                 byte_ok_r;
  logic [7:0]           rd_data_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [7:0]           ld_ex, ld_ey;
  logic [AW-1:0]        pix_addr;
  logic                 pix_inside;
  logic signed [11:0]   e2, dx_s, dy_s, err_sum;
  logic                 step_x, step_y;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [7:0]           mem_wd;
  logic                 clr_last;

  // A pixel command is a line whose ends coincide
  assign ld_ex = (in_data.cmd == CMD_PIXEL) ? in_data.start_x : in_data.end_x;
  assign ld_ey = (in_data.cmd == CMD_PIXEL) ? in_data.start_y : in_data.end_y;

  // Linear address only matters inside the panel, where it fits AW bits
  assign pix_addr   = AW'(y_r[7:3]) * AW'(PANEL_WIDTH) + AW'(x_r);
  assign pix_inside = (32'(x_r) < PANEL_WIDTH) && (32'(y_r) < PANEL_HEIGHT);

  assign e2      = signed'({err_r, 1'b0});
  assign dx_s    = signed'(12'(dx_r));
  assign dy_s    = signed'(12'(dy_r));
  assign step_x  = e2 > -dy_s;
  assign step_y  = e2 < dx_s;
  assign err_sum = 12'(err_r) - (step_x ? dy_s : 12'sd0) + (step_y ? dx_s : 12'sd0);

  assign clr_last = (32'(clr_addr_r) == DEPTH - 1);

  assign mem_we = cmd.clr || (cmd.wr_pix && inside_r);
  assign mem_wa = cmd.clr ? clr_addr_r : addr_r;
  assign mem_wd = cmd.clr ? 8'd0 : (on_r ? (rd_data_r | mask_r) : (rd_data_r & ~mask_r));
  assign mem_re = cmd.rd_pix || cmd.rd_byte;
  assign mem_ra = cmd.rd_byte ? byte_addr_r : pix_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r       <= in_data.cmd;
      x_r         <= in_data.start_x;
      y_r         <= in_data.start_y;
      ex_r        <= ld_ex;
      ey_r        <= ld_ey;
      dx_r        <= (ld_ex > in_data.start_x) ? ld_ex - in_data.start_x
                                               : in_data.start_x - ld_ex;
      dy_r        <= (ld_ey > in_data.start_y) ? ld_ey - in_data.start_y
                                               : in_data.start_y - ld_ey;
      sx_neg_r    <= !(in_data.start_x < ld_ex);
      sy_neg_r    <= !(in_data.start_y < ld_ey);
      err_r       <= 11'(signed'({3'b000, (ld_ex > in_data.start_x) ?
                                   ld_ex - in_data.start_x : in_data.start_x - ld_ex}))
                   - 11'(signed'({3'b000, (ld_ey > in_data.start_y) ?
                                   ld_ey - in_data.start_y : in_data.start_y - ld_ey}));
      on_r        <= (in_data.cmd == CMD_PIXEL) ? in_data.pixel_on : 1'b1;
      count_r     <= '0;
      byte_addr_r <= AW'(in_data.read_page) * AW'(PANEL_WIDTH) + AW'(in_data.read_column);
      byte_ok_r   <= (32'(in_data.read_page) < PAGES) &&
                     (32'(in_data.read_column) < PANEL_WIDTH);
    end
    if (cmd.rd_pix) begin
      addr_r   <= pix_addr;
      mask_r   <= 8'd1 << y_r[2:0];
      inside_r <= pix_inside;
    end
    // Write back the current pixel and advance one Bresenham step
    if (cmd.wr_pix) begin
      count_r <= count_r + 9'(inside_r);
      err_r   <= 11'(err_sum);
      if (step_x) begin
        x_r <= sx_neg_r ? x_r - 8'd1 : x_r + 8'd1;
      end
      if (step_y) begin
        y_r <= sy_neg_r ? y_r - 8'd1 : y_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + AW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.column_byte    <= (cmd_r == CMD_READ && byte_ok_r) ? rd_data_r : 8'd0;
      out_data_r.pixels_written <= count_r;
    end
  end

  assign status.in_cmd     = in_data.cmd;
  assign status.last_pixel = (x_r == ex_r) && (y_r == ey_r);
  assign status.clr_last   = clr_last;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lrpf_ctrl.sv =====
module lrpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrpf_pkg::dp_status_t status,
  output lrpf_pkg::ctrl_cmd_t  cmd
);
  import lrpf_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT    = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_PIX_RD  = 7'b0000100,
    ST_PIX_WR  = 7'b0001000,
    ST_BYTE_RD = 7'b0010000,
    ST_CLEAR   = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (status.in_cmd) inside
            CMD_LINE, CMD_PIXEL: state_nxt = ST_PIX_RD;
            CMD_READ:            state_nxt = ST_BYTE_RD;
            default:             state_nxt = ST_CLEAR;
          endcase
        end
      end
      ST_PIX_RD: begin
        cmd.rd_pix = 1'b1;
        state_nxt  = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd.wr_pix = 1'b1;
        state_nxt  = status.last_pixel ? ST_DONE : ST_PIX_RD;
      end
      ST_BYTE_RD: begin
        cmd.rd_byte = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/line_raster_page_framebuffer_unit.sv =====
// Monochrome page-layout framebuffer with a Bresenham line rasteriser. The
// store holds one byte per column per page (a page is a band of 8 rows, bit n
// is row page*8+n). Commands: 0 draw a line between two inclusive endpoints,
// 1 set or clear one pixel, 2 read one column byte, 3 clear the store.
// Pixels off the panel are walked but neither stored nor counted. Each command
// gives one result transfer carrying the byte read (reads only) and the number
// of pixels stored. One command is in work at a time; a line or pixel command
// does a read-modify-write of the frame memory for each visited pixel, and a
// clear sweeps every byte of the store to zero. After reset the block sweeps
// the memory to zero and holds in_stall high meanwhile. A finished result sits
// in an output register, so the next command is taken while the previous
// result still waits.
module line_raster_page_framebuffer_unit #(
  parameter int unsigned PANEL_WIDTH  = 128,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrpf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lrpf_pkg::out_item_t out_data
);
  import lrpf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence the commands: clearing sweeps, pixel read-modify-write, result hand-off
  lrpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Frame memory, line walker and output register
  lrpf_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb_line_raster_page_framebuffer_unit.sv =====
module tb_line_raster_page_framebuffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lrpf_pkg::*;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_PAGES  = (PANEL_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int STORE_BYTES  = STORE_PAGES * PANEL_WIDTH;

  localparam int     RANDOM_ITEMS = 1050;
  // Worst case per command is a full clear plus the longest sender gap and
  // receiver stall; take that over every item and then several times over, with
  // room for the reset sweep.
  localparam longint CYCLE_LIMIT  = 6_000_000;
  // Longest single command is a clear; wait that long again for stray results.
  localparam int     TAIL_CYCLES  = 1100;

  // Mirror of the frame store plus the queue of results still owed by the block.
  class raster_checker;
    bit [7:0]    frame_bytes [STORE_BYTES];
    out_item_t   awaited_results [$];
    int unsigned mismatch_count;

    task report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Store one pixel if it lies on the panel; return 1 when it was stored.
    function int unsigned plot_pixel(input int x, input int y, input bit lit);
      int idx;
      if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return 0;
      idx = (y / ROWS_PER_PAGE) * PANEL_WIDTH + x;
      frame_bytes[idx][y % ROWS_PER_PAGE] = lit;
      return 1;
    endfunction

    // Apply an accepted command to the mirror and queue the result it owes.
    function void note_command(input in_item_t item);
      out_item_t   want;
      int          x, y, ex, ey, dx, dy, sx, sy, err, e2;
      int unsigned lit_count;
      want      = '0;
      lit_count = 0;
      case (item.cmd)
        CMD_LINE: begin
          x   = item.start_x;
          y   = item.start_y;
          ex  = item.end_x;
          ey  = item.end_y;
          dx  = (ex > x) ? ex - x : x - ex;
          dy  = (ey > y) ? ey - y : y - ey;
          sx  = (x < ex) ? 1 : -1;
          sy  = (y < ey) ? 1 : -1;
          err = dx - dy;
          // Walk every visited pixel, on panel or not; only stored ones count.
          for (int step = 0; step < 512; step++) begin
            lit_count += plot_pixel(x, y, 1'b1);
            if (x == ex && y == ey) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
              err -= dy;
              x   += sx;
            end
            if (e2 < dx) begin
              err += dx;
              y   += sy;
            end
          end
        end
        CMD_PIXEL: begin
          lit_count = plot_pixel(item.start_x, item.start_y, item.pixel_on);
        end
        CMD_READ: begin
          if (item.read_page < STORE_PAGES && item.read_column < PANEL_WIDTH)
            want.column_byte = frame_bytes[item.read_page * PANEL_WIDTH + item.read_column];
        end
        CMD_CLEAR: begin
          foreach (frame_bytes[i]) frame_bytes[i] = '0;
        end
      endcase
      want.pixels_written = lit_count[8:0];
      awaited_results.push_back(want);
    endfunction

    // Compare one result transfer with the oldest owed result.
    task check_result(input out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: byte %02h, pixels %0d",
                                  got.column_byte, got.pixels_written));
        return;
      end
      want = awaited_results.pop_front();
      if (got.column_byte !== want.column_byte)
        report_mismatch($sformatf("column_byte %02h, expected %02h",
                                  got.column_byte, want.column_byte));
      if (got.pixels_written !== want.pixels_written)
        report_mismatch($sformatf("pixels_written %0d, expected %0d",
                                  got.pixels_written, want.pixels_written));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  raster_checker frame_ref = new();

  // Set during stretches where neither side idles.
  bit     steady_flow = 1'b0;
  int     stall_left  = 0;
  longint cycle_count = 0;

  line_raster_page_framebuffer_unit #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no pause, some short ones and the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_command(input logic [1:0] cmd,
                                            input int sx, input int sy,
                                            input int ex, input int ey,
                                            input bit lit, input int pg, input int col);
    in_item_t item;
    item.cmd         = cmd;
    item.start_x     = sx[7:0];
    item.start_y     = sy[7:0];
    item.end_x       = ex[7:0];
    item.end_y       = ey[7:0];
    item.pixel_on    = lit;
    item.read_page   = pg[2:0];
    item.read_column = col[6:0];
    return item;
  endfunction

  function automatic in_item_t random_command();
    in_item_t    item;
    int unsigned pick;
    // Fill every field at full range, then narrow what the command uses.
    item.start_x     = 8'($urandom_range(0, 255));
    item.start_y     = 8'($urandom_range(0, 255));
    item.end_x       = 8'($urandom_range(0, 255));
    item.end_y       = 8'($urandom_range(0, 255));
    item.pixel_on    = 1'($urandom_range(0, 1));
    item.read_page   = 3'($urandom_range(0, 7));
    item.read_column = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      item.cmd = CMD_LINE;
      // Keep most lines on or just past the panel so that they land and clip.
      if ($urandom_range(0, 4) != 0) begin
        item.start_x = 8'($urandom_range(0, PANEL_WIDTH + 7));
        item.start_y = 8'($urandom_range(0, PANEL_HEIGHT + 7));
        item.end_x   = 8'($urandom_range(0, PANEL_WIDTH + 7));
        item.end_y   = 8'($urandom_range(0, PANEL_HEIGHT + 7));
      end
    end else if (pick < 55) begin
      item.cmd = CMD_PIXEL;
      if ($urandom_range(0, 6) != 0) begin
        item.start_x = 8'($urandom_range(0, PANEL_WIDTH - 1));
        item.start_y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
      end
    end else if (pick < 97) begin
      item.cmd = CMD_READ;
    end else begin
      item.cmd = CMD_CLEAR;
    end
    return item;
  endfunction

  // Offer one command and hold it until the transfer happens; valid stays high
  // across back-to-back commands.
  task automatic send_command(input in_item_t item);
    int unsigned gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    frame_ref.note_command(item);
  endtask

  // Drop valid and hold off until every owed result has arrived.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_ref.awaited_results.size() != 0);
  endtask

  // Result side: check each transfer, then choose the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) frame_ref.check_result(out_data);
    if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: give up if the run has clearly hung.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands: extremes, clipping, repeats and every command code.
    send_command(make_command(CMD_READ,    9,   9,   9,   9, 1'b0, 0,   0));
    send_command(make_command(CMD_LINE,    0,   0, 255, 255, 1'b0, 7, 127));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b1, 7,  63));
    // Anti-diagonal over the full range: walks entirely off the panel.
    send_command(make_command(CMD_LINE,  255,   0,   0, 255, 1'b1, 0,   0));
    send_command(make_command(CMD_LINE,  127,   0,   0,  63, 1'b0, 3,  64));
    // Single-point line.
    send_command(make_command(CMD_LINE,    5,   5,   5,   5, 1'b1, 5,  85));
    send_command(make_command(CMD_LINE,    0,  10, 127,  10, 1'b0, 2,  42));
    send_command(make_command(CMD_LINE,  100,  63, 100,   0, 1'b1, 6,  21));
    send_command(make_command(CMD_LINE,    3,   0,  10,  63, 1'b0, 1, 106));
    send_command(make_command(CMD_LINE,  200, 100, 255, 255, 1'b1, 4,  17));
    // Partly clipped at the bottom-right corner.
    send_command(make_command(CMD_LINE,  120,  60, 140,  70, 1'b0, 3,  99));
    // Light a pixel, light it again (still counted), then darken it.
    send_command(make_command(CMD_PIXEL, 127,  63,   0,   0, 1'b1, 0,   0));
    send_command(make_command(CMD_PIXEL, 127,  63, 255, 255, 1'b1, 7, 127));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b0, 7, 127));
    send_command(make_command(CMD_PIXEL, 127,  63,   0,   0, 1'b0, 0,   0));
    send_command(make_command(CMD_READ,  255, 255, 255, 255, 1'b1, 7, 127));
    // Pixels just off the right and bottom edges and at the far corner of the coordinate range.
    send_command(make_command(CMD_PIXEL, 128,   0,   0,   0, 1'b1, 0,   0));
    send_command(make_command(CMD_PIXEL,   0,  64,   0,   0, 1'b1, 0,   0));
    send_command(make_command(CMD_PIXEL, 255, 255,   0,   0, 1'b1, 0,   0));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b0, 1,  10));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b0, 0,   5));
    send_command(make_command(CMD_CLEAR,  77, 188,  34, 201, 1'b1, 5,  90));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b0, 1,  10));
    send_command(make_command(CMD_READ,    0,   0,   0,   0, 1'b0, 7,  63));

    // Let the pipeline empty fully before the random part.
    wait_results_drained();

    // Random commands; every third block of 150 runs with no idling at all.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady_flow = (n % 450 == 150);
      if (n == RANDOM_ITEMS / 2) wait_results_drained();
      send_command(random_command());
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_ref.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
